// ===== rtl/amfr_pkg.sv =====
// ----------------------------------------------------------------------------
// amfr_pkg
// Shared constants and types for the audio module frame receiver.
// ----------------------------------------------------------------------------
package amfr_pkg;

	localparam int FRAME_BYTES = 10;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

	// byte positions inside a frame
	localparam logic [POS_W-1:0] POS_START   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SUM_LO  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_SUM_HI  = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CMD     = POS_W'(3);
	localparam logic [POS_W-1:0] POS_FEED    = POS_W'(4);
	localparam logic [POS_W-1:0] POS_PARAM_H = POS_W'(5);
	localparam logic [POS_W-1:0] POS_PARAM_L = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CHK_H   = POS_W'(7);
	localparam logic [POS_W-1:0] POS_CHK_L   = POS_W'(8);

	// configuration register indexes
	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	localparam logic [7:0] START_MARKER_RST = 8'h7E;
	localparam logic [7:0] END_MARKER_RST   = 8'hEF;

	localparam logic [7:0]  CMD_POWER_ON   = 8'h3F;
	localparam logic [7:0]  CMD_TRACK_DONE = 8'h3D;
	localparam logic [15:0] PARAM_CARD     = 16'h0002;

	localparam logic [1:0] EV_NONE           = 2'd0;
	localparam logic [1:0] EV_CARD_ONLINE    = 2'd1;
	localparam logic [1:0] EV_TRACK_FINISHED = 2'd2;

	typedef struct packed {
		logic        frame_ok;
		logic        marker_error;
		logic        checksum_error;
		logic [7:0]  command_code;
		logic [7:0]  feedback_flag;
		logic [15:0] parameter_word;
		logic [1:0]  event_code;
	} result_t;

	typedef struct packed {
		logic step;   // byte moves into the frame state this cycle
		logic last;   // byte in the input register closes the frame
	} frame_ctl_t;

	function automatic logic [1:0] decode_event(input logic [7:0] cmd,
			input logic [15:0] param);
		logic [1:0] ev;
		ev = EV_NONE;
		if (cmd == CMD_POWER_ON && param == PARAM_CARD) begin
			ev = EV_CARD_ONLINE;
		end else if (cmd == CMD_TRACK_DONE) begin
			ev = EV_TRACK_FINISHED;
		end
		return ev;
	endfunction

endpackage

// ===== rtl/audio_module_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// audio_module_frame_receiver
// Groups received serial bytes into fixed ten-byte frames and reports the
// marker and checksum checks and the decoded event once per frame.
// ----------------------------------------------------------------------------
//  channel  | signals                         | moves
//  rx       | rx_valid, rx_stall, rx_byte     | one received byte per transfer
//  res      | res_valid, res_stall, fields    | one frame result per ten bytes
//  cfg      | cfg_write, cfg_index, cfg_data  | marker register write
//
// one byte per cycle while a closing byte is not held by res_stall: input register, frame logic, result register
// a result is loaded into the result register after its tenth byte has passed the
// input register, and waits while the previous result is still stalled
// reset clears the byte count, so framing starts from the first byte after it
// res_stall holds back only a closing byte; other bytes keep flowing
// ----------------------------------------------------------------------------
module audio_module_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        frame_ok,
	output logic        marker_error,
	output logic        checksum_error,
	output logic [7:0]  command_code,
	output logic [7:0]  feedback_flag,
	output logic [15:0] parameter_word,
	output logic [1:0]  event_code,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import amfr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;
	logic       res_valid_q;
	result_t    res_q;
	result_t    frame_res;
	frame_ctl_t ctl;
	logic       out_free;
	logic       rx_take;

	assign out_free = !res_valid_q || !res_stall;
	assign ctl.step = valid_s1 && (!ctl.last || out_free);
	assign rx_stall = valid_s1 && !ctl.step;
	assign rx_take  = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (ctl.step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx_byte;
		end
	end

	amfr_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (ctl.step),
		.byte_in      (byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.last         (ctl.last),
		.result       (frame_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.step && ctl.last) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && ctl.last) begin
			res_q <= frame_res;
		end
	end

	assign res_valid      = res_valid_q;
	assign frame_ok       = res_q.frame_ok;
	assign marker_error   = res_q.marker_error;
	assign checksum_error = res_q.checksum_error;
	assign command_code   = res_q.command_code;
	assign feedback_flag  = res_q.feedback_flag;
	assign parameter_word = res_q.parameter_word;
	assign event_code     = res_q.event_code;

endmodule

// ===== rtl/amfr_frame.sv =====
// ----------------------------------------------------------------------------
// amfr_frame
// Frame state: byte position, running sum and held fields, plus the
// end-of-frame checks and event decode.
// ----------------------------------------------------------------------------
module amfr_frame (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          byte_in,
	input  logic [7:0]          start_marker,
	input  logic [7:0]          end_marker,
	output logic                last,
	output amfr_pkg::result_t   result
);
	import amfr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic             start_good_q;
	logic [7:0]       cmd_q;
	logic [7:0]       feed_q;
	logic [15:0]      param_q;
	logic [15:0]      check_q;
	logic             merr;
	logic             cerr;

	assign last = (pos_q >= LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			sum_q        <= '0;
			start_good_q <= 1'b0;
			cmd_q        <= '0;
			feed_q       <= '0;
			param_q      <= '0;
			check_q      <= '0;
		end else if (step) begin
			if (last) begin
				pos_q        <= '0;
				sum_q        <= '0;
				start_good_q <= 1'b0;
				cmd_q        <= '0;
				feed_q       <= '0;
				param_q      <= '0;
				check_q      <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q == POS_START) begin
					start_good_q <= (byte_in == start_marker);
				end
				if (pos_q >= POS_SUM_LO && pos_q <= POS_SUM_HI) begin
					sum_q <= sum_q + {8'h00, byte_in};
				end
				if (pos_q == POS_CMD) begin
					cmd_q <= byte_in;
				end
				if (pos_q == POS_FEED) begin
					feed_q <= byte_in;
				end
				if (pos_q == POS_PARAM_H) begin
					param_q[15:8] <= byte_in;
				end
				if (pos_q == POS_PARAM_L) begin
					param_q[7:0] <= byte_in;
				end
				if (pos_q == POS_CHK_H) begin
					check_q[15:8] <= byte_in;
				end
				if (pos_q == POS_CHK_L) begin
					check_q[7:0] <= byte_in;
				end
			end
		end
	end

	// checksum is the two's complement of the sum, so the two add up to zero
	always_comb begin
		merr = !start_good_q || (byte_in != end_marker);
		cerr = ((check_q + sum_q) != 16'h0000);
		result.frame_ok       = !merr && !cerr;
		result.marker_error   = merr;
		result.checksum_error = cerr;
		result.command_code   = cmd_q;
		result.feedback_flag  = feed_q;
		result.parameter_word = param_q;
		result.event_code     = decode_event(cmd_q, param_q);
	end

endmodule

// ===== rtl/amfr_checker.sv =====
// ----------------------------------------------------------------------------
// amfr_checker
// Port-level checks on the frame receiver's result channel.
// ----------------------------------------------------------------------------
module amfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic        frame_ok,
	input logic        marker_error,
	input logic        checksum_error,
	input logic [7:0]  command_code,
	input logic [7:0]  feedback_flag,
	input logic [15:0] parameter_word,
	input logic [1:0]  event_code
);
	import amfr_pkg::*;

	// a stalled result stays until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_ok_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (frame_ok == (!marker_error && !checksum_error)))
		else $error("frame_ok disagrees with error flags");

	a_card_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && event_code == EV_CARD_ONLINE |->
			command_code == CMD_POWER_ON && parameter_word == PARAM_CARD)
		else $error("card online event without its command");

	a_track_event: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((command_code == CMD_TRACK_DONE) ==
			(event_code == EV_TRACK_FINISHED)))
		else $error("track finished event mismatch");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (event_code == EV_NONE || event_code == EV_CARD_ONLINE ||
			event_code == EV_TRACK_FINISHED))
		else $error("event code out of range");

endmodule

bind audio_module_frame_receiver amfr_checker u_amfr_checker (.*);
